FILE: rtl/core/frustum_cull_test_core_macros.svh
// Assertion helpers shared by the culling core.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge of clk_i
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define FCT_ASSERT(lbl, prop, msg)
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/fct_pkg.sv
`default_nettype none
package fct_pkg;

  // Geometry of the plane chain
  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PLANE_W    = 64;

  // Field widths
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned EXT_W      = 15;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ABS_SUM_W  = 17;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned EXTRA_W    = 32;
  localparam int unsigned BIAS_W     = 34;
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned FRAC_SHIFT = 14;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_POINT    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SPHERE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CUBE     = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_CUBE_ALT = 2'd3;

  // One primitive travelling down the chain, with its running verdict
  typedef struct packed {
    logic [TYPE_W-1:0]         req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [EXT_W-1:0]          extent;
    logic                      survive;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/core/fct_cell.sv
`default_nettype none
`include "frustum_cull_test_core_macros.svh"
module fct_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         plane_we_i,
  input  logic [fct_pkg::PLANE_W-1:0]  plane_data_i,
  input  logic                         in_valid_i,
  input  fct_pkg::item_t               in_item_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output fct_pkg::item_t               out_item_o,
  input  logic                         out_ready_i
);

  // Plane storage and its precomputed |A|+|B|+|C|
  logic [fct_pkg::PLANE_W-1:0]   plane_q;
  logic [fct_pkg::ABS_SUM_W-1:0] abs_sum_q, abs_sum_d;
  logic signed [fct_pkg::COEF_W-1:0] wr_a, wr_b, wr_c;
  logic [fct_pkg::COEF_W-1:0] abs_a, abs_b, abs_c;
  logic signed [fct_pkg::COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;

  // Stage one: products and bias
  logic                               s1_valid_q;
  fct_pkg::item_t                     s1_item_q;
  logic signed [fct_pkg::PROD_W-1:0]  prod_a_q, prod_b_q, prod_c_q;
  logic signed [fct_pkg::PROD_W-1:0]  prod_a_d, prod_b_d, prod_c_d;
  logic signed [fct_pkg::BIAS_W-1:0]  bias_q, bias_d;
  logic [fct_pkg::EXTRA_W-1:0]        extra_d;
  logic                               s1_ready;

  // Stage two: sum, compare, verdict
  logic                               s2_valid_q;
  fct_pkg::item_t                     s2_item_q, s2_item_d;
  logic signed [fct_pkg::SUM_W-1:0]   dist_sum;
  logic                               reject;
  logic                               s2_ready;

  // Split incoming write data and take absolute values
  assign wr_a  = plane_data_i[15:0];
  assign wr_b  = plane_data_i[31:16];
  assign wr_c  = plane_data_i[47:32];
  assign abs_a = wr_a[fct_pkg::COEF_W-1] ? fct_pkg::COEF_W'(-wr_a) : wr_a;
  assign abs_b = wr_b[fct_pkg::COEF_W-1] ? fct_pkg::COEF_W'(-wr_b) : wr_b;
  assign abs_c = wr_c[fct_pkg::COEF_W-1] ? fct_pkg::COEF_W'(-wr_c) : wr_c;
  assign abs_sum_d = fct_pkg::ABS_SUM_W'(abs_a) + fct_pkg::ABS_SUM_W'(abs_b)
                   + fct_pkg::ABS_SUM_W'(abs_c);

  // Load the plane on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q   <= '0;
      abs_sum_q <= '0;
    end else if (plane_we_i) begin
      plane_q   <= plane_data_i;
      abs_sum_q <= abs_sum_d;
    end
  end

  assign coef_a = plane_q[15:0];
  assign coef_b = plane_q[31:16];
  assign coef_c = plane_q[47:32];
  assign coef_d = plane_q[63:48];

  // Form the three products of the normal with the center
  assign prod_a_d = coef_a * in_item_i.pos_x;
  assign prod_b_d = coef_b * in_item_i.pos_y;
  assign prod_c_d = coef_c * in_item_i.pos_z;

  // Select the extent term by request kind
  always_comb begin
    case (in_item_i.req_type) inside
      fct_pkg::REQ_POINT:  extra_d = '0;
      fct_pkg::REQ_SPHERE: extra_d = {3'b000, in_item_i.extent, 14'b0};
      fct_pkg::REQ_CUBE, fct_pkg::REQ_CUBE_ALT:
        extra_d = fct_pkg::EXTRA_W'(in_item_i.extent) * fct_pkg::EXTRA_W'(abs_sum_q);
      default:             extra_d = '0;
    endcase
  end

  // Bias is D aligned to the product scale plus the extent term
  assign bias_d = {{(fct_pkg::BIAS_W - fct_pkg::COEF_W - fct_pkg::FRAC_SHIFT)
                    {coef_d[fct_pkg::COEF_W-1]}},
                   coef_d, {fct_pkg::FRAC_SHIFT{1'b0}}}
                + {{(fct_pkg::BIAS_W - fct_pkg::EXTRA_W){1'b0}}, extra_d};

  // Handshake between stages: a stage takes new data when empty or draining
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_item_q <= in_item_i;
      prod_a_q  <= prod_a_d;
      prod_b_q  <= prod_b_d;
      prod_c_q  <= prod_c_d;
      bias_q    <= bias_d;
    end
  end

  // Sum the distance and drop the survive flag on reject
  assign dist_sum = fct_pkg::SUM_W'(prod_a_q) + fct_pkg::SUM_W'(prod_b_q)
                  + fct_pkg::SUM_W'(prod_c_q) + fct_pkg::SUM_W'(bias_q);
  assign reject   = dist_sum[fct_pkg::SUM_W-1] || (dist_sum == '0);

  always_comb begin
    s2_item_d         = s1_item_q;
    s2_item_d.survive = s1_item_q.survive && !reject;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = s2_item_q;

  // A rejected item never regains the survive flag
  `FCT_ASSERT_NEXT(a_survive_sticky, s1_valid_q && s2_ready && !s1_item_q.survive, s2_valid_q && !s2_item_q.survive, "survive flag set again after reject")
  // An item in stage one moves on when stage two can take it
  `FCT_ASSERT_NEXT(a_s1_advance, s1_valid_q && s2_ready, s2_valid_q, "stage one item lost")
  // A stalled result holds its verdict
  `FCT_ASSERT_NEXT(a_s2_hold, s2_valid_q && !out_ready_i, s2_valid_q && $stable(s2_item_q), "stalled result changed")

endmodule
`default_nettype wire

FILE: rtl/core/frustum_cull_test_core.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   req_type_i pos_x_i pos_y_i pos_z_i extent_i
// out       output     out_valid_o/out_ready_i inside_res_o
// cfg       input      cfg_we_i                cfg_idx_i cfg_data_i
//
// One item per cycle sustained while out_ready_i is high; items pass through six plane cells of
// two register stages each (multiplies, then sum and compare).
// Every stage takes new data when it is empty or its successor drains, so
// bubbles collapse and input is taken while a result waits at the output.
// Reset clears all planes to zero and empties the chain.
// Plane writes take effect at once and must come only while the chain is idle.
module frustum_cull_test_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fct_pkg::PLANE_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fct_pkg::TYPE_W-1:0]      req_type_i,
  input  logic signed [fct_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [fct_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [fct_pkg::COORD_W-1:0] pos_z_i,
  input  logic [fct_pkg::EXT_W-1:0]       extent_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            inside_res_o
);

  logic           chain_valid [fct_pkg::NUM_PLANES+1];
  logic           chain_ready [fct_pkg::NUM_PLANES+1];
  fct_pkg::item_t chain_item  [fct_pkg::NUM_PLANES+1];

  // Start each item with the survive flag set
  always_comb begin
    chain_item[0].req_type = req_type_i;
    chain_item[0].pos_x    = pos_x_i;
    chain_item[0].pos_y    = pos_y_i;
    chain_item[0].pos_z    = pos_z_i;
    chain_item[0].extent   = extent_i;
    chain_item[0].survive  = 1'b1;
  end

  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  // One cell per plane, written by its register index
  for (genvar g = 0; g < fct_pkg::NUM_PLANES; g++) begin : g_cell
    logic plane_we;
    assign plane_we = cfg_we_i && (cfg_idx_i == fct_pkg::CFG_IDX_W'(g));

    fct_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .plane_we_i   (plane_we),
      .plane_data_i (cfg_data_i),
      .in_valid_i   (chain_valid[g]),
      .in_item_i    (chain_item[g]),
      .in_ready_o   (chain_ready[g]),
      .out_valid_o  (chain_valid[g+1]),
      .out_item_o   (chain_item[g+1]),
      .out_ready_i  (chain_ready[g+1])
    );
  end

  // Last cell's stage two is the output register
  assign chain_ready[fct_pkg::NUM_PLANES] = out_ready_i;
  assign out_valid_o  = chain_valid[fct_pkg::NUM_PLANES];
  assign inside_res_o = chain_item[fct_pkg::NUM_PLANES].survive;

endmodule
`default_nettype wire
